// ----- src/ttsf_pkg.sv -----
// Shared constants, types and the digit-to-segment table for the
// temperature display-update framer. No dependencies.
package ttsf_pkg;

    localparam int unsigned TempW   = 12;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned FrameN  = 7;
    localparam int unsigned IdxW    = $clog2(FrameN);

    // Bus command bytes
    localparam logic [ByteW-1:0] CmdData = 8'h40;
    localparam logic [ByteW-1:0] CmdAddr = 8'hC0;
    localparam logic [ByteW-1:0] CmdCtrl = 8'h8B;

    // Segment patterns
    localparam logic [ByteW-1:0] SegPoint = 8'h80;
    localparam logic [ByteW-1:0] SegMinus = 8'h40;
    localparam logic [ByteW-1:0] SegCel   = 8'h39;
    localparam logic [ByteW-1:0] SegBlank = 8'h00;
    localparam logic [ByteW-1:0] SegNine  = 8'h6F;

    // Magnitude in tenths at which the display saturates to 99.9
    localparam logic [TempW-1:0] SatTenths = 12'd1000;

    // Byte positions within one update
    localparam logic [IdxW-1:0] PosData = 3'd0;
    localparam logic [IdxW-1:0] PosAddr = 3'd1;
    localparam logic [IdxW-1:0] PosSeg0 = 3'd2;
    localparam logic [IdxW-1:0] PosSeg1 = 3'd3;
    localparam logic [IdxW-1:0] PosSeg2 = 3'd4;
    localparam logic [IdxW-1:0] PosSeg3 = 3'd5;
    localparam logic [IdxW-1:0] PosCtrl = 3'd6;

    // Four segment bytes, leftmost digit first
    typedef struct packed {
        logic [ByteW-1:0] seg0;
        logic [ByteW-1:0] seg1;
        logic [ByteW-1:0] seg2;
        logic [ByteW-1:0] seg3;
    } t_segs;

    // Serializer status toward the input stage
    typedef struct packed {
        logic load_ok;   // a new request may be loaded this cycle
    } t_ser_status;

    function automatic logic [ByteW-1:0] seg_digit(input logic [3:0] d);
        logic [ByteW-1:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ----- src/ttsf_decode.sv -----
// Combinational decode of a registered temperature request into four
// segment bytes. Depends on ttsf_pkg.
module ttsf_decode
    import ttsf_pkg::*;
(
    input  logic             i_cmd,
    input  logic [TempW-1:0] i_temp,
    output t_segs            o_segs
);

    logic             neg;
    logic [TempW-1:0] mag;
    logic             sat;
    logic [9:0]       m10;
    logic [15:0]      prod_hi;
    logic [3:0]       d_hi;
    logic [6:0]       rem_hi;
    logic [17:0]      prod_un;
    logic [3:0]       d_un;
    logic [3:0]       d_te;

    always_comb begin
        neg = i_temp[TempW-1];
        mag = neg ? (~i_temp + 12'd1) : i_temp;
        sat = (mag >= SatTenths);
        m10 = mag[9:0];
        // divide by 100: exact for values below 1000
        prod_hi = {6'd0, m10} * 16'd41;
        d_hi    = prod_hi[15:12];
        rem_hi  = 7'(m10 - 10'(d_hi) * 10'd100);
        // divide by 10: exact for values below 1029
        prod_un = {11'd0, rem_hi} * 18'd205;
        d_un    = prod_un[14:11];
        d_te    = 4'(rem_hi - 7'(d_un) * 7'd10);

        if (i_cmd) begin
            o_segs = '{SegBlank, SegBlank, SegBlank, SegBlank};
        end else if (sat) begin
            o_segs = '{SegNine, SegNine | SegPoint, SegNine, SegCel};
        end else begin
            o_segs.seg0 = neg ? SegMinus : ((d_hi == 4'd0) ? SegBlank : seg_digit(d_hi));
            o_segs.seg1 = seg_digit(d_un) | SegPoint;
            o_segs.seg2 = seg_digit(d_te);
            o_segs.seg3 = SegCel;
        end
    end

endmodule

// ----- src/ttsf_serial.sv -----
// Frame serializer: holds one update's segment bytes and walks the seven
// bus bytes out over a valid/ready channel. Depends on ttsf_pkg.
module ttsf_serial
    import ttsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_segs            i_segs,
    output t_ser_status      o_status,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ByteW-1:0] o_bus_byte,
    output logic             o_start_before,
    output logic             o_stop_after,
    output logic             o_last
);

    logic            r_busy, n_busy;
    logic [IdxW-1:0] r_idx, n_idx;
    t_segs           r_segs;
    logic            fire;
    logic            at_end;

    assign fire   = r_busy && i_ready;
    assign at_end = (r_idx == PosCtrl);
    assign o_status.load_ok = !r_busy || (fire && at_end);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (fire) begin
            if (at_end) begin
                n_busy = 1'b0;
                n_idx  = PosData;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (i_load) begin
            n_busy = 1'b1;
            n_idx  = PosData;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= PosData;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_segs <= i_segs;
        end
    end

    assign o_valid = r_busy;

    always_comb begin
        o_bus_byte     = CmdCtrl;
        o_start_before = 1'b0;
        o_stop_after   = 1'b0;
        o_last         = 1'b0;
        unique case (r_idx)
            PosData: begin
                o_bus_byte     = CmdData;
                o_start_before = 1'b1;
                o_stop_after   = 1'b1;
            end
            PosAddr: begin
                o_bus_byte     = CmdAddr;
                o_start_before = 1'b1;
            end
            PosSeg0: o_bus_byte = r_segs.seg0;
            PosSeg1: o_bus_byte = r_segs.seg1;
            PosSeg2: o_bus_byte = r_segs.seg2;
            PosSeg3: begin
                o_bus_byte   = r_segs.seg3;
                o_stop_after = 1'b1;
            end
            PosCtrl: begin
                o_bus_byte     = CmdCtrl;
                o_start_before = 1'b1;
                o_stop_after   = 1'b1;
                o_last         = 1'b1;
            end
            default: begin
                o_bus_byte = CmdCtrl;
            end
        endcase
    end

endmodule

// ----- src/temp_to_seven_segment_frame.sv -----
// Top level of the temperature display-update framer: input register,
// segment decode and frame serializer. Depends on ttsf_pkg, ttsf_decode,
// ttsf_serial.
//
// Each request carries a command bit and a signed temperature in tenths of a
// degree. It produces seven bus bytes, one per cycle while the sink is ready:
// 0x40 (start+stop), 0xC0 (start), four segment bytes (stop after the
// fourth), 0x8B (start+stop, last). Non-negative values show a blanked-zero
// tens digit, units with point, tenths and 'C'; negative values show a
// minus in place of the tens digit. Magnitudes of 100.0 or more read "99.9C"
// without sign; the clear command blanks all four segments. The serializer
// emits one byte per cycle while the sink is ready. From input accept, a
// request passes the input register, then combinational decode into the
// serializer's segment register, before its first byte goes out.
// The next request is accepted while the current frame is still going out,
// so with a ready sink frames follow each other with no gap.
module temp_to_seven_segment_frame
    import ttsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_cmd,
    input  logic [TempW-1:0] i_temperature_tenths,
    // byte channel
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ByteW-1:0] o_bus_byte,
    output logic             o_start_before,
    output logic             o_stop_after,
    output logic             o_last
);

    // Input register: holds one request until the serializer takes it
    logic             r_in_valid;
    logic             r_cmd;
    logic [TempW-1:0] r_temp;
    logic             in_fire;
    logic             load;
    t_segs            segs;
    t_ser_status      ser_status;

    assign load    = r_in_valid && ser_status.load_ok;
    assign o_ready = !r_in_valid || load;
    assign in_fire = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= i_cmd;
            r_temp <= i_temperature_tenths;
        end
    end

    // Digits and segment bytes from the registered request
    ttsf_decode u_decode (
        .i_cmd  (r_cmd),
        .i_temp (r_temp),
        .o_segs (segs)
    );

    // Seven-byte frame out
    ttsf_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_segs         (segs),
        .o_status       (ser_status),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bus_byte     (o_bus_byte),
        .o_start_before (o_start_before),
        .o_stop_after   (o_stop_after),
        .o_last         (o_last)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for temp_to_seven_segment_frame: drives temperature and
// clear requests, predicts the seven-byte display update of each and checks every
// byte on the output channel. Depends on ttsf_pkg and the temp_to_seven_segment_frame RTL.
module tb_top;
    import ttsf_pkg::*;

    localparam int RandomCount  = 450;
    localparam int CycleLimit   = 200000;
    localparam int SettleCycles = 20;
    localparam int ReportMax    = 10;
    localparam int IdlePct      = 34;
    localparam int SatLevel     = int'(SatTenths);

    // Digit glyphs 0..9, index 0 at the low end
    localparam logic [9:0][ByteW-1:0] Glyph = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             start_mark;
        logic             stop_mark;
        logic             final_byte;
    } t_bus_word;

    logic             i_clk                = 1'b0;
    logic             i_rst_n              = 1'b0;
    logic             i_valid              = 1'b0;
    logic             i_cmd                = 1'b0;
    logic [TempW-1:0] i_temperature_tenths = '0;
    logic             i_ready              = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [ByteW-1:0] o_bus_byte;
    logic             o_start_before;
    logic             o_stop_after;
    logic             o_last;

    t_bus_word pending_bytes[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    logic      steady         = 1'b0;   // no idling on either side while set

    temp_to_seven_segment_frame DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_cmd                (i_cmd),
        .i_temperature_tenths (i_temperature_tenths),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_bus_byte           (o_bus_byte),
        .o_start_before       (o_start_before),
        .o_stop_after         (o_stop_after),
        .o_last               (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Expected update for one request, appended in bus order
    function automatic void queue_display_update(input logic cmd,
                                                 input logic [TempW-1:0] temp);
        int               value;
        int               mag;
        logic [ByteW-1:0] s0;
        logic [ByteW-1:0] s1;
        logic [ByteW-1:0] s2;
        logic [ByteW-1:0] s3;
        value = int'($signed(temp));
        mag   = (value < 0) ? -value : value;
        s0 = SegBlank;
        s1 = SegBlank;
        s2 = SegBlank;
        s3 = SegBlank;
        if (!cmd) begin
            if (mag >= SatLevel) begin
                // saturated reading, sign dropped
                s0 = Glyph[9];
                s1 = Glyph[9] | SegPoint;
                s2 = Glyph[9];
            end else begin
                if (value < 0) begin
                    s0 = SegMinus;
                end else if ((mag / 100) % 10 == 0) begin
                    s0 = SegBlank;
                end else begin
                    s0 = Glyph[(mag / 100) % 10];
                end
                s1 = Glyph[(mag / 10) % 10] | SegPoint;
                s2 = Glyph[mag % 10];
            end
            s3 = SegCel;
        end
        pending_bytes.push_back(t_bus_word'{CmdData, 1'b1, 1'b1, 1'b0});
        pending_bytes.push_back(t_bus_word'{CmdAddr, 1'b1, 1'b0, 1'b0});
        pending_bytes.push_back(t_bus_word'{s0, 1'b0, 1'b0, 1'b0});
        pending_bytes.push_back(t_bus_word'{s1, 1'b0, 1'b0, 1'b0});
        pending_bytes.push_back(t_bus_word'{s2, 1'b0, 1'b0, 1'b0});
        pending_bytes.push_back(t_bus_word'{s3, 1'b0, 1'b1, 1'b0});
        pending_bytes.push_back(t_bus_word'{CmdCtrl, 1'b1, 1'b1, 1'b1});
    endfunction

    // One request: optional random gap, then hold valid until accepted.
    // Valid is left high on return; the next call or a pause lowers it.
    task automatic send_request(input logic cmd, input logic [TempW-1:0] temp);
        while (!steady && $urandom_range(99) < IdlePct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid              <= 1'b1;
        i_cmd                <= cmd;
        i_temperature_tenths <= temp;
        do @(posedge i_clk); while (!o_ready);
        queue_display_update(cmd, temp);
    endtask

    task automatic drain_updates();
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    // Sink side: random stalls and byte-by-byte comparison
    always @(posedge i_clk) begin
        t_bus_word want;
        i_ready <= steady || ($urandom_range(99) >= IdlePct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_bytes.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < ReportMax)
                    $display("unexpected byte %h start %b stop %b last %b",
                             o_bus_byte, o_start_before, o_stop_after, o_last);
            end else begin
                want = pending_bytes.pop_front();
                if (want.data !== o_bus_byte || want.start_mark !== o_start_before ||
                    want.stop_mark !== o_stop_after || want.final_byte !== o_last) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < ReportMax)
                        $display("byte mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                                 want.data, want.start_mark, want.stop_mark,
                                 want.final_byte, o_bus_byte, o_start_before,
                                 o_stop_after, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("temp_to_seven_segment_frame verification failed");
            $finish;
        end
    end

    // Field extremes, digit boundaries, zero, sign and saturation edges
    task automatic test_directed_values();
        send_request(1'b0, 12'sd0);
        send_request(1'b0, 12'sd1);
        send_request(1'b0, -12'sd1);
        send_request(1'b0, 12'sd5);
        send_request(1'b0, 12'sd99);
        send_request(1'b0, 12'sd100);
        send_request(1'b0, 12'sd123);
        send_request(1'b0, -12'sd10);
        send_request(1'b0, -12'sd987);
        send_request(1'b0, 12'sd999);
        send_request(1'b0, -12'sd999);
        send_request(1'b0, 12'sd1000);
        send_request(1'b0, -12'sd1000);
        send_request(1'b0, 12'sd2047);
        send_request(1'b0, 12'h800);
    endtask

    // Clear ignores the temperature entirely
    task automatic test_clear_command();
        send_request(1'b1, 12'h000);
        send_request(1'b1, 12'h7FF);
        send_request(1'b1, 12'h800);
        send_request(1'b1, 12'hFFF);
        send_request(1'b1, 12'h555);
    endtask

    // Sender holds off until every pending byte has gone out
    task automatic test_drain_pause();
        send_request(1'b0, 12'sd456);
        send_request(1'b0, -12'sd42);
        drain_updates();
        send_request(1'b0, 12'sd777);
    endtask

    function automatic logic [TempW-1:0] random_temperature();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return TempW'($signed($urandom_range(1998)) - 999);
        else if (pick < 80)
            return TempW'($signed($urandom_range(40)) - 20);
        else
            return TempW'($urandom);
    endfunction

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
            send_request($urandom_range(99) < 15, random_temperature());
    endtask

    // Long stretch with no idling on either side: frames should run back to back
    task automatic test_back_to_back();
        steady <= 1'b1;
        test_random_traffic(60);
        steady <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_values();
        test_clear_command();
        test_drain_pause();
        test_random_traffic(RandomCount / 2);
        test_back_to_back();
        test_random_traffic(RandomCount - RandomCount / 2 - 60);

        drain_updates();
        repeat (SettleCycles) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bytes.size() == 0) begin
            $display("temp_to_seven_segment_frame verification clean");
        end else begin
            $display("temp_to_seven_segment_frame verification failed");
        end
        $finish;
    end

endmodule
